### src/csmabo_pkg.sv
// ----------------------------------------------------------------------------
// csmabo_pkg - shared types and constants of the csma-ca backoff controller
// Phase encoding, result status codes, register map, configuration and
// result records, and the exponent helper functions.
// ----------------------------------------------------------------------------
package csmabo_pkg;

    // highest backoff exponent the block works with
    localparam logic [3:0] EXP_LIMIT = 4'd8;

    // packet phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_BACKOFF = 2'd1,
        PH_TX      = 2'd2
    } t_phase;

    // result status codes
    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_TX_START = 3'd1;
    localparam logic [2:0] ST_TX_DONE  = 3'd2;
    localparam logic [2:0] ST_DROPPED  = 3'd3;
    localparam logic [2:0] ST_REFUSED  = 3'd4;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_MIN_EXP      = 2'd0;
    localparam logic [1:0] REG_MAX_EXP      = 2'd1;
    localparam logic [1:0] REG_MAX_BACKOFFS = 2'd2;
    localparam logic [1:0] REG_TX_DURATION  = 2'd3;

    // register reset values
    localparam logic [3:0] RST_MIN_EXP      = 4'd3;
    localparam logic [3:0] RST_MAX_EXP      = 4'd5;
    localparam logic [2:0] RST_MAX_BACKOFFS = 3'd4;
    localparam logic [7:0] RST_TX_DURATION  = 8'd10;

    typedef struct packed {
        logic [3:0] min_exponent;
        logic [3:0] max_exponent;
        logic [2:0] max_backoffs;
        logic [7:0] tx_duration;
    } t_cfg;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] attempts;
        logic [3:0] exponent;
        logic       active;
    } t_result;

    // exponent limited to EXP_LIMIT
    function automatic logic [3:0] clamp_exp(input logic [3:0] e);
        return (e > EXP_LIMIT) ? EXP_LIMIT : e;
    endfunction

    // random wait: low e bits of the draw, all 8 bits for e of 8 or more
    function automatic logic [7:0] draw_wait(input logic [7:0] draw, input logic [3:0] e);
        logic [7:0] mask;
        for (int i = 0; i < 8; i++) begin
            mask[i] = (4'(i) < e);
        end
        return draw & mask;
    endfunction

endpackage

### src/csma_ca_backoff_controller.sv
// ----------------------------------------------------------------------------
// csma_ca_backoff_controller - unslotted csma-ca medium access controller
// Top level: apb configuration, input beat register, packet state machine
// and result register.
// ----------------------------------------------------------------------------
// Usage
//   Input stream: one beat per backoff period tick (tuser 0) or packet request
//   (tuser 1); tdata carries the channel-clear flag and 8 random bits.
//   Output stream: exactly one result beat per input beat, in order: status in
//   tuser, attempts / exponent / active in tdata.
//   Each beat passes the input register, then the result register. Throughput
//   is one beat per cycle unless the receiver stalls: the state machine updates
//   in a single pass from the input register to the result register.
//   A result waiting in the result register does not block the input: the
//   next beat is still captured into the input register, and only when both
//   registers are full and the receiver stalls does s_axis tready drop.
//   Reset (synchronous, active low) empties both registers, returns the
//   packet state to idle and loads the register defaults (min exponent 3,
//   max exponent 5, max backoffs 4, tx duration 10).
//   Registers are to be written over apb only while the stream is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module csma_ca_backoff_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [0] cca_clear, [8:1] random_draw, rest zero
    input  logic [0:0]  i_s_axis_tuser,   // [0] opcode
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [3:0] attempts, [7:4] exponent, [8] active
    output logic [2:0]  o_m_axis_tuser,   // [2:0] status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    csmabo_pkg::t_cfg    w_cfg;
    csmabo_pkg::t_result w_result;
    csmabo_pkg::t_phase  w_phase;

    logic                r_in_vld;
    logic                r_in_opcode;
    logic                r_in_clear;
    logic [7:0]          r_in_draw;
    logic                r_out_vld;
    csmabo_pkg::t_result r_out_res;
    logic                w_adv;
    logic                w_in_acc;

    // configuration registers
    csmabo_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // pipeline control
    assign w_adv           = r_in_vld & (~r_out_vld | i_m_axis_tready);
    assign o_s_axis_tready = ~r_in_vld | w_adv;
    assign w_in_acc        = i_s_axis_tvalid & o_s_axis_tready;

    // input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_opcode <= i_s_axis_tuser[0];
            r_in_clear  <= i_s_axis_tdata[0];
            r_in_draw   <= i_s_axis_tdata[8:1];
        end
    end

    // packet state machine
    csmabo_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_opcode      (r_in_opcode),
        .i_cca_clear   (r_in_clear),
        .i_random_draw (r_in_draw),
        .i_cfg         (w_cfg),
        .o_result      (w_result),
        .o_phase       (w_phase)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_res <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_out_res.status;
    assign o_m_axis_tdata  = {7'd0, r_out_res.active, r_out_res.exponent, r_out_res.attempts};

    // a processed beat reports active exactly when the packet stays in progress
    a_active_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_out_res.active == (w_phase != csmabo_pkg::PH_IDLE)))
        else $error("result active flag disagrees with packet phase");

    // end of packet always reports an inactive controller
    a_end_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_res.status == csmabo_pkg::ST_TX_DONE ||
                       r_out_res.status == csmabo_pkg::ST_DROPPED)) |-> !r_out_res.active)
        else $error("finished packet still reported active");

    // a transmission start leaves the state machine in the transmit phase
    a_tx_start_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_result.status == csmabo_pkg::ST_TX_START) |=>
        (w_phase == csmabo_pkg::PH_TX))
        else $error("tx start without transmit phase");

    // reported exponent stays within the limit
    a_exp_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_res.exponent <= csmabo_pkg::EXP_LIMIT))
        else $error("backoff exponent above limit");

endmodule

### src/csmabo_cfg.sv
// ----------------------------------------------------------------------------
// csmabo_cfg - configuration register file
// Four apb registers holding the backoff exponent range, the busy limit and
// the transmission length.
// ----------------------------------------------------------------------------
module csmabo_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output csmabo_pkg::t_cfg   o_cfg
);

    csmabo_pkg::t_cfg r_cfg;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_exponent <= csmabo_pkg::RST_MIN_EXP;
            r_cfg.max_exponent <= csmabo_pkg::RST_MAX_EXP;
            r_cfg.max_backoffs <= csmabo_pkg::RST_MAX_BACKOFFS;
            r_cfg.tx_duration  <= csmabo_pkg::RST_TX_DURATION;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                csmabo_pkg::REG_MIN_EXP:      r_cfg.min_exponent <= pwdata[3:0];
                csmabo_pkg::REG_MAX_EXP:      r_cfg.max_exponent <= pwdata[3:0];
                csmabo_pkg::REG_MAX_BACKOFFS: r_cfg.max_backoffs <= pwdata[2:0];
                csmabo_pkg::REG_TX_DURATION:  r_cfg.tx_duration  <= pwdata[7:0];
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (paddr[3:2])
            csmabo_pkg::REG_MIN_EXP:      prdata = {28'd0, r_cfg.min_exponent};
            csmabo_pkg::REG_MAX_EXP:      prdata = {28'd0, r_cfg.max_exponent};
            csmabo_pkg::REG_MAX_BACKOFFS: prdata = {29'd0, r_cfg.max_backoffs};
            csmabo_pkg::REG_TX_DURATION:  prdata = {24'd0, r_cfg.tx_duration};
        endcase
    end

endmodule

### src/csmabo_core.sv
// ----------------------------------------------------------------------------
// csmabo_core - csma-ca packet state machine
// Holds phase, countdown, busy count and exponent, and works out one result
// per beat from the registered input beat in a single pass.
// ----------------------------------------------------------------------------
module csmabo_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_opcode,
    input  logic                  i_cca_clear,
    input  logic [7:0]            i_random_draw,
    input  csmabo_pkg::t_cfg      i_cfg,
    output csmabo_pkg::t_result   o_result,
    output csmabo_pkg::t_phase    o_phase
);

    csmabo_pkg::t_phase r_phase,     n_phase;
    logic [8:0]         r_countdown, n_countdown;
    logic [3:0]         r_busy,      n_busy;
    logic [3:0]         r_exp,       n_exp;

    logic [3:0] w_lim;
    logic [3:0] w_exp_min;
    logic [4:0] w_exp_inc;
    logic [3:0] w_exp_busy;
    logic [3:0] w_busy_inc;
    logic       w_finished;

    assign o_phase = r_phase;

    // state registers, advanced once per processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= csmabo_pkg::PH_IDLE;
            r_countdown <= 9'd0;
            r_busy      <= 4'd0;
            r_exp       <= 4'd0;
        end else if (i_adv) begin
            r_phase     <= n_phase;
            r_countdown <= n_countdown;
            r_busy      <= n_busy;
            r_exp       <= n_exp;
        end
    end

    // exponent arithmetic shared by the branches
    assign w_lim      = csmabo_pkg::clamp_exp(i_cfg.max_exponent);
    assign w_exp_min  = csmabo_pkg::clamp_exp(i_cfg.min_exponent);
    assign w_exp_inc  = {1'b0, r_exp} + 5'd1;
    assign w_exp_busy = (w_exp_inc > {1'b0, w_lim}) ? w_lim : w_exp_inc[3:0];
    assign w_busy_inc = r_busy + 4'd1;

    // next state and result
    always_comb begin
        n_phase         = r_phase;
        n_countdown     = r_countdown;
        n_busy          = r_busy;
        n_exp           = r_exp;
        w_finished      = 1'b0;
        o_result.status = csmabo_pkg::ST_NONE;

        if (i_opcode) begin
            // packet request
            if (r_phase == csmabo_pkg::PH_IDLE) begin
                n_busy      = 4'd0;
                n_exp       = w_exp_min;
                n_countdown = {1'b0, csmabo_pkg::draw_wait(i_random_draw, w_exp_min)};
                n_phase     = csmabo_pkg::PH_BACKOFF;
            end else begin
                o_result.status = csmabo_pkg::ST_REFUSED;
            end
        end else begin
            // backoff period tick
            unique case (r_phase)
                csmabo_pkg::PH_BACKOFF: begin
                    if (r_countdown != 9'd0) begin
                        n_countdown = r_countdown - 9'd1;
                    end else if (i_cca_clear) begin
                        n_phase         = csmabo_pkg::PH_TX;
                        n_countdown     = {1'b0, i_cfg.tx_duration};
                        o_result.status = csmabo_pkg::ST_TX_START;
                    end else begin
                        n_busy = w_busy_inc;
                        n_exp  = w_exp_busy;
                        if (w_busy_inc <= {1'b0, i_cfg.max_backoffs}) begin
                            n_countdown = 9'd1 +
                                {1'b0, csmabo_pkg::draw_wait(i_random_draw, w_exp_busy)};
                        end else begin
                            o_result.status = csmabo_pkg::ST_DROPPED;
                            w_finished      = 1'b1;
                        end
                    end
                end
                csmabo_pkg::PH_TX: begin
                    if (r_countdown <= 9'd1) begin
                        o_result.status = csmabo_pkg::ST_TX_DONE;
                        w_finished      = 1'b1;
                    end else begin
                        n_countdown = r_countdown - 9'd1;
                    end
                end
                default: begin
                end
            endcase
        end

        // report the packet's values before the end-of-packet clear
        o_result.attempts = n_busy;
        o_result.exponent = n_exp;

        if (w_finished) begin
            n_phase     = csmabo_pkg::PH_IDLE;
            n_countdown = 9'd0;
            n_busy      = 4'd0;
            n_exp       = 4'd0;
        end

        o_result.active = (n_phase != csmabo_pkg::PH_IDLE);
    end

endmodule
